/* rtl/core/cpt_pkg.sv */
// shared types and constants of the cyclic pump timer
// no dependencies; used by the interfaces, cpt_tick and the top level

package cpt_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_START_PRESET = 2'd0;
	localparam logic [1:0] CFG_DEBOUNCE     = 2'd1;
	localparam logic [1:0] CFG_GREEN_THRESH = 2'd2;
	localparam logic [1:0] CFG_OVERLAY      = 2'd3;

	localparam int unsigned CFG_DATA_W = 27;
	localparam int unsigned MS_W       = 27;
	localparam int unsigned SECS_W     = 18;
	localparam int unsigned MINS_W     = 12;
	localparam int unsigned HOURS_W    = 7;
	localparam int unsigned VALUE_W    = 10;

	// reset values of the configuration registers
	localparam logic [7:0]        DEBOUNCE_RST = 8'd50;
	localparam logic [MS_W-1:0]   GREEN_RST    = 27'd300000;
	localparam logic [15:0]       OVERLAY_RST  = 16'd2000;

	localparam logic [31:0] ON_TIME_MS = 32'd60000;

	// largest seconds figure still shown in seconds, and in minutes
	localparam logic [SECS_W-1:0] SECS_SHOWN_MAX = 18'd120;
	localparam logic [MINS_W-1:0] MINS_SHOWN_MAX = 12'd120;
	localparam logic [5:0]        HALF_MINUTE    = 6'd30;

	// floor(x / d) = (x * ceil(2^s / d)) >> s, exact over the operand width
	localparam logic [27:0] RECIP_1000_27 = 28'd137438954;   // s = 37
	localparam int unsigned SHIFT_1000    = 37;
	localparam logic [18:0] RECIP_60_18   = 19'd279621;      // s = 24
	localparam int unsigned SHIFT_60_18   = 24;
	localparam logic [12:0] RECIP_60_12   = 13'd4370;        // s = 18
	localparam int unsigned SHIFT_60_12   = 18;

	typedef enum logic [1:0] {
		UNIT_SEC  = 2'd0,
		UNIT_MIN  = 2'd1,
		UNIT_HOUR = 2'd2
	} unit_t;

	typedef enum logic [1:0] {
		LIGHT_OFF   = 2'd0,
		LIGHT_RED   = 2'd1,
		LIGHT_GREEN = 2'd2,
		LIGHT_BLUE  = 2'd3
	} light_t;

	// off interval per preset, the seven-row table repeated for indexes past six
	localparam logic [MS_W-1:0] REST_MS [16] = '{
		27'd1800000, 27'd7200000, 27'd21600000, 27'd86400000,
		27'd60000,   27'd240000,  27'd600000,
		27'd1800000, 27'd7200000, 27'd21600000, 27'd86400000,
		27'd60000,   27'd240000,  27'd600000,
		27'd1800000, 27'd7200000
	};

	// per-tick result of the timer state update
	typedef struct packed {
		logic            pump_on;
		logic [MS_W-1:0] left_ms;
		light_t          light;
		logic            changed;
	} tick_res_t;

endpackage

/* rtl/core/cpt_if.sv */
// valid/ready stream interfaces of the cyclic pump timer
// depends on cpt_pkg

interface cpt_tick_if;
	logic valid;
	logic ready;
	logic button_level;

	modport source (output valid, output button_level, input ready);
	modport sink (input valid, input button_level, output ready);
endinterface

interface cpt_disp_if #(
	parameter int unsigned PRESET_W = 3
);
	logic                         valid;
	logic                         ready;
	logic                         pump_on;
	logic [PRESET_W-1:0]          preset_index;
	logic [cpt_pkg::VALUE_W-1:0]  countdown_value;
	logic [1:0]                   countdown_unit;
	logic [1:0]                   backlight;
	logic                         preset_changed;

	modport source (output valid, output pump_on, output preset_index,
		output countdown_value, output countdown_unit, output backlight,
		output preset_changed, input ready);
	modport sink (input valid, input pump_on, input preset_index,
		input countdown_value, input countdown_unit, input backlight,
		input preset_changed, output ready);
endinterface

/* rtl/core/cpt_tick.sv */
// timer state: debounce, preset stepping, on/off phase and overlay
// depends on cpt_pkg; instantiated by cyclic_pump_timer_with_presets_core

module cpt_tick #(
	parameter int unsigned NUM_PRESETS = 7,
	parameter int unsigned TIMER_BITS  = 27,
	parameter int unsigned PRESET_W    = 3
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  logic                             level,
	input  logic                             cfg_wr_en,
	input  logic [1:0]                       cfg_index,
	input  logic [cpt_pkg::CFG_DATA_W-1:0]   cfg_data,
	output cpt_pkg::tick_res_t               res,
	output logic [PRESET_W-1:0]              preset
);

	logic [7:0]                 debounce_ticks_q;
	logic [cpt_pkg::MS_W-1:0]   green_q;
	logic [15:0]                overlay_ticks_q;

	logic                  running_q;
	logic [TIMER_BITS-1:0] elapsed_q;
	logic [PRESET_W-1:0]   preset_q;
	logic                  prev_level_q;
	logic [7:0]            deb_cnt_q;
	logic                  stable_q;
	logic [15:0]           ov_cnt_q;
	logic                  ov_act_q;

	logic                  deb_clr;
	logic [7:0]            deb_cnt;
	logic                  accept_level;
	logic                  press;
	logic [PRESET_W:0]     preset_inc;
	logic [PRESET_W-1:0]   preset_d;
	logic                  run_mid;
	logic [TIMER_BITS-1:0] el_mid;
	logic [15:0]           ov_cnt_mid;
	logic                  ov_act_mid;
	logic [cpt_pkg::MS_W-1:0] rest;
	logic                  run_d;
	logic [TIMER_BITS-1:0] el_d;
	logic                  ov_act_d;
	logic [cpt_pkg::MS_W-1:0] left;
	logic [PRESET_W-1:0]   cfg_preset;

	always_comb begin
		deb_clr      = (level != prev_level_q);
		deb_cnt      = deb_clr ? 8'd0 : deb_cnt_q;
		accept_level = (deb_cnt >= debounce_ticks_q) && (level != stable_q);
		press        = accept_level && level;

		preset_inc = {1'b0, preset_q} + (PRESET_W+1)'(1);
		if (!press) begin
			preset_d = preset_q;
		end else if (32'(preset_inc) >= NUM_PRESETS) begin
			preset_d = '0;
		end else begin
			preset_d = preset_inc[PRESET_W-1:0];
		end

		run_mid    = press ? 1'b0 : running_q;
		el_mid     = press ? '0 : elapsed_q;
		ov_cnt_mid = press ? 16'd0 : ov_cnt_q;
		ov_act_mid = press ? 1'b1 : ov_act_q;

		rest = cpt_pkg::REST_MS[4'(preset_d)];

		// phase switch
		run_d = run_mid;
		el_d  = el_mid;
		if (run_mid) begin
			if (32'(el_mid) >= cpt_pkg::ON_TIME_MS) begin
				run_d = 1'b0;
				el_d  = '0;
			end
		end else if (32'(el_mid) >= 32'(rest)) begin
			run_d = 1'b1;
			el_d  = '0;
		end

		ov_act_d = ov_act_mid && (ov_cnt_mid < overlay_ticks_q);

		// the on phase never reaches its end here, the switch above saw to it
		if (run_d) begin
			left = cpt_pkg::MS_W'(cpt_pkg::ON_TIME_MS - 32'(el_d));
		end else if (32'(el_d) < 32'(rest)) begin
			left = cpt_pkg::MS_W'(32'(rest) - 32'(el_d));
		end else begin
			left = '0;
		end

		res.pump_on = run_d;
		res.left_ms = left;
		res.changed = press;
		if (ov_act_d) begin
			res.light = cpt_pkg::LIGHT_BLUE;
		end else if (run_d) begin
			res.light = cpt_pkg::LIGHT_RED;
		end else if (left < green_q) begin
			res.light = cpt_pkg::LIGHT_GREEN;
		end else begin
			res.light = cpt_pkg::LIGHT_OFF;
		end
		preset = preset_d;

		cfg_preset = (32'(cfg_data[2:0]) < NUM_PRESETS) ? PRESET_W'(cfg_data[2:0]) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= cpt_pkg::DEBOUNCE_RST;
			green_q          <= cpt_pkg::GREEN_RST;
			overlay_ticks_q  <= cpt_pkg::OVERLAY_RST;
			running_q        <= 1'b1;
			elapsed_q        <= '0;
			preset_q         <= '0;
			prev_level_q     <= 1'b0;
			deb_cnt_q        <= 8'd0;
			stable_q         <= 1'b0;
			ov_cnt_q         <= 16'd0;
			ov_act_q         <= 1'b0;
		end else begin
			if (step) begin
				running_q    <= run_d;
				elapsed_q    <= (el_d != '1) ? el_d + TIMER_BITS'(1) : el_d;
				prev_level_q <= level;
				deb_cnt_q    <= (deb_cnt != 8'hff) ? deb_cnt + 8'd1 : deb_cnt;
				stable_q     <= accept_level ? level : stable_q;
				ov_cnt_q     <= (ov_cnt_mid != 16'hffff) ? ov_cnt_mid + 16'd1 : ov_cnt_mid;
				ov_act_q     <= ov_act_d;
			end
			// a start preset write wins over the beat's own preset step
			if (cfg_wr_en && cfg_index == cpt_pkg::CFG_START_PRESET) begin
				preset_q <= cfg_preset;
			end else if (step) begin
				preset_q <= preset_d;
			end
			if (cfg_wr_en) begin
				unique case (cfg_index)
					cpt_pkg::CFG_START_PRESET: ;
					cpt_pkg::CFG_DEBOUNCE:     debounce_ticks_q <= cfg_data[7:0];
					cpt_pkg::CFG_GREEN_THRESH: green_q          <= cfg_data;
					cpt_pkg::CFG_OVERLAY:      overlay_ticks_q  <= cfg_data[15:0];
				endcase
			end
		end
	end

endmodule

/* rtl/core/cyclic_pump_timer_with_presets_core.sv */
// Cyclic pump duty timer, one input beat per millisecond tick and one output beat per
// tick. Every beat updates the timer state in the cycle it is accepted; the countdown
// is then turned into seconds, minutes or hours by three constant-reciprocal
// multiplications, one per register stage, so a result passes stages s1 to s4 before
// it leaves. A new tick is accepted every cycle unless stalled; the output stage
// stalls the pipeline only when every stage holds a beat and the sink is not ready.
// depends on cpt_pkg, cpt_if and cpt_tick

module cyclic_pump_timer_with_presets_core #(
	parameter int unsigned NUM_PRESETS = 7,
	parameter int unsigned TIMER_BITS  = 27
) (
	input  logic                           clk,
	input  logic                           arst_n,
	cpt_tick_if.sink                       tick,
	cpt_disp_if.source                     disp,
	input  logic                           cfg_wr_en,
	input  logic [1:0]                     cfg_index,
	input  logic [cpt_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned PRESET_W = (NUM_PRESETS > 1) ? $clog2(NUM_PRESETS) : 1;

	cpt_pkg::tick_res_t  res;
	logic [PRESET_W-1:0] preset;
	logic                accept;
	logic                en2, en3, en4;

	logic                v_s1, v_s2, v_s3, v_s4;
	logic                pump_s1, pump_s2, pump_s3, pump_s4;
	logic [PRESET_W-1:0] preset_s1, preset_s2, preset_s3, preset_s4;
	cpt_pkg::light_t     light_s1, light_s2, light_s3, light_s4;
	logic                chg_s1, chg_s2, chg_s3, chg_s4;
	logic [cpt_pkg::MS_W-1:0]    left_s1;
	logic [cpt_pkg::SECS_W-1:0]  secs_s2;
	logic                        small_s3;
	logic [6:0]                  secs_s3;
	logic [cpt_pkg::MINS_W-1:0]  mins_s3;
	logic [cpt_pkg::VALUE_W-1:0] value_s4;
	cpt_pkg::unit_t              unit_s4;

	logic [54:0] prod_sec;
	logic [cpt_pkg::SECS_W-1:0] secs_rnd;
	logic [36:0] prod_min;
	logic [cpt_pkg::MINS_W-1:0] mins_rnd;
	logic [24:0] prod_hr;
	logic [cpt_pkg::HOURS_W-1:0] hours;

	cpt_tick #(
		.NUM_PRESETS (NUM_PRESETS),
		.TIMER_BITS  (TIMER_BITS),
		.PRESET_W    (PRESET_W)
	) u_tick (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (accept),
		.level     (tick.button_level),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res       (res),
		.preset    (preset)
	);

	// a stage takes a new beat when it is empty or its content moves on
	assign en4        = !v_s4 || disp.ready;
	assign en3        = !v_s3 || en4;
	assign en2        = !v_s2 || en3;
	assign tick.ready = !v_s1 || en2;
	assign accept     = tick.valid && tick.ready;

	always_comb begin
		prod_sec = 55'(left_s1) * 55'(cpt_pkg::RECIP_1000_27);
		secs_rnd = secs_s2 + cpt_pkg::SECS_W'(cpt_pkg::HALF_MINUTE);
		prod_min = 37'(secs_rnd) * 37'(cpt_pkg::RECIP_60_18);
		mins_rnd = mins_s3 + cpt_pkg::MINS_W'(cpt_pkg::HALF_MINUTE);
		prod_hr  = 25'(mins_rnd) * 25'(cpt_pkg::RECIP_60_12);
		hours    = cpt_pkg::HOURS_W'(prod_hr >> cpt_pkg::SHIFT_60_12);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (tick.ready) v_s1 <= accept;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pump_s1   <= res.pump_on;
			preset_s1 <= preset;
			light_s1  <= res.light;
			chg_s1    <= res.changed;
			left_s1   <= res.left_ms;
		end
		if (en2) begin
			pump_s2   <= pump_s1;
			preset_s2 <= preset_s1;
			light_s2  <= light_s1;
			chg_s2    <= chg_s1;
			secs_s2   <= cpt_pkg::SECS_W'(prod_sec >> cpt_pkg::SHIFT_1000);
		end
		if (en3) begin
			pump_s3   <= pump_s2;
			preset_s3 <= preset_s2;
			light_s3  <= light_s2;
			chg_s3    <= chg_s2;
			small_s3  <= (secs_s2 <= cpt_pkg::SECS_SHOWN_MAX);
			secs_s3   <= secs_s2[6:0];
			mins_s3   <= cpt_pkg::MINS_W'(prod_min >> cpt_pkg::SHIFT_60_18);
		end
		if (en4) begin
			pump_s4   <= pump_s3;
			preset_s4 <= preset_s3;
			light_s4  <= light_s3;
			chg_s4    <= chg_s3;
			// longest interval is a day, so no figure gets near the 10-bit limit
			if (small_s3) begin
				value_s4 <= cpt_pkg::VALUE_W'(secs_s3);
				unit_s4  <= cpt_pkg::UNIT_SEC;
			end else if (mins_s3 > cpt_pkg::MINS_SHOWN_MAX) begin
				value_s4 <= cpt_pkg::VALUE_W'(hours);
				unit_s4  <= cpt_pkg::UNIT_HOUR;
			end else begin
				value_s4 <= cpt_pkg::VALUE_W'(mins_s3);
				unit_s4  <= cpt_pkg::UNIT_MIN;
			end
		end
	end

	assign disp.valid           = v_s4;
	assign disp.pump_on         = pump_s4;
	assign disp.preset_index    = preset_s4;
	assign disp.countdown_value = value_s4;
	assign disp.countdown_unit  = unit_s4;
	assign disp.backlight       = light_s4;
	assign disp.preset_changed  = chg_s4;

endmodule

/* tb/cpt_display_checker.sv */
// display stream checker for the cyclic pump timer: follows tick beats and register
// writes, predicts each display beat and compares it with what the block sends
// depends on cpt_pkg and the stream interfaces in cpt_if

module cpt_display_checker #(
	parameter int unsigned NUM_PRESETS = 7,
	parameter int unsigned TIMER_BITS  = 27
) (
	input  logic                           clk,
	input  logic                           arst_n,
	cpt_tick_if                            tick,
	cpt_disp_if                            disp,
	input  logic                           cfg_wr_en,
	input  logic [1:0]                     cfg_index,
	input  logic [cpt_pkg::CFG_DATA_W-1:0] cfg_data,
	output int unsigned                    mismatches,
	output int unsigned                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import cpt_pkg::*;

	localparam int unsigned RUN_MS = 60000;
	localparam int unsigned REST_TAB [7] = '{
		1800000, 7200000, 21600000, 86400000, 60000, 240000, 600000
	};

	typedef struct packed {
		logic       pump_on;
		logic [3:0] preset;
		logic [9:0] shown;
		unit_t      unit;
		light_t     light;
		logic       changed;
	} disp_beat_t;

	// register copies
	logic [7:0]  cfg_debounce;
	logic [26:0] cfg_green;
	logic [15:0] cfg_overlay;

	// timer state
	logic                  running;
	logic [TIMER_BITS-1:0] phase_ms;
	logic [3:0]            sel;
	logic                  last_level;
	logic [7:0]            bounce_cnt;
	logic                  settled_level;
	logic [15:0]           overlay_cnt;
	logic                  overlay_on;

	disp_beat_t display_due [$];

	function automatic disp_beat_t next_display(input logic level);
		disp_beat_t beat;
		int unsigned rest, left, secs, mins, shown;
		beat = '0;
		if (level != last_level) begin
			bounce_cnt = '0;
		end
		if (bounce_cnt >= cfg_debounce && level != settled_level) begin
			settled_level = level;
			// accepted press: next preset, pump stops, off phase restarts, overlay opens
			if (level) begin
				sel = (sel + 1) % NUM_PRESETS;
				running = 1'b0;
				phase_ms = '0;
				overlay_on = 1'b1;
				overlay_cnt = '0;
				beat.changed = 1'b1;
			end
		end
		last_level = level;

		rest = REST_TAB[sel % 7];
		if (running) begin
			if (phase_ms >= RUN_MS) begin
				running = 1'b0;
				phase_ms = '0;
			end
		end else if (phase_ms >= rest) begin
			running = 1'b1;
			phase_ms = '0;
		end

		if (overlay_on && overlay_cnt >= cfg_overlay) begin
			overlay_on = 1'b0;
		end

		if (running) begin
			shown = (phase_ms < RUN_MS) ? (RUN_MS - phase_ms) / 1000 : 0;
			beat.unit = UNIT_SEC;
			beat.light = LIGHT_RED;
		end else begin
			left = (phase_ms < rest) ? rest - phase_ms : 0;
			secs = left / 1000;
			if (secs <= 120) begin
				shown = secs;
				beat.unit = UNIT_SEC;
			end else begin
				mins = (secs + 30) / 60;
				if (mins > 120) begin
					shown = (mins + 30) / 60;
					beat.unit = UNIT_HOUR;
				end else begin
					shown = mins;
					beat.unit = UNIT_MIN;
				end
			end
			beat.light = (left < cfg_green) ? LIGHT_GREEN : LIGHT_OFF;
		end
		if (shown > 1023) begin
			shown = 1023;
		end
		if (overlay_on) begin
			beat.light = LIGHT_BLUE;
		end

		beat.pump_on = running;
		beat.preset = sel;
		beat.shown = shown[9:0];

		if (phase_ms != '1) begin
			phase_ms++;
		end
		if (bounce_cnt != 8'hff) begin
			bounce_cnt++;
		end
		if (overlay_cnt != 16'hffff) begin
			overlay_cnt++;
		end
		return beat;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		mismatches = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		disp_beat_t want;
		if (!arst_n) begin
			cfg_debounce = DEBOUNCE_RST;
			cfg_green = 27'd300000;
			cfg_overlay = OVERLAY_RST;
			running = 1'b1;
			phase_ms = '0;
			sel = '0;
			last_level = 1'b0;
			bounce_cnt = '0;
			settled_level = 1'b0;
			overlay_cnt = '0;
			overlay_on = 1'b0;
			display_due.delete();
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_START_PRESET: begin
						sel = (cfg_data[2:0] < NUM_PRESETS) ? cfg_data[2:0] : 3'd0;
					end
					CFG_DEBOUNCE: begin
						cfg_debounce = cfg_data[7:0];
					end
					CFG_GREEN_THRESH: begin
						cfg_green = cfg_data[26:0];
					end
					CFG_OVERLAY: begin
						cfg_overlay = cfg_data[15:0];
					end
				endcase
			end
			if (tick.valid && tick.ready) begin
				display_due.push_back(next_display(tick.button_level));
			end
			if (disp.valid && disp.ready) begin
				if (display_due.size() == 0) begin
					$error("display beat arrived with no tick waiting for it");
					mismatches++;
				end else begin
					want = display_due.pop_front();
					check_field("pump_on", want.pump_on, disp.pump_on);
					check_field("preset_index", want.preset, disp.preset_index);
					check_field("countdown_value", want.shown, disp.countdown_value);
					check_field("countdown_unit", want.unit, disp.countdown_unit);
					check_field("backlight", want.light, disp.backlight);
					check_field("preset_changed", want.changed, disp.preset_changed);
				end
			end
			outstanding <= display_due.size();
		end
	end

endmodule

/* tb/testbench.sv */
// top of the cyclic pump timer bench: clock, reset, register writes, button beats
// and random stalls on both streams; checking lives in cpt_display_checker
// depends on cpt_pkg, cpt_if, cpt_display_checker and the core

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cpt_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [26:0] cfg_data;

	int unsigned idle_pct;
	int unsigned debounce_now;
	int unsigned ticks_sent;
	int unsigned mismatches;
	int unsigned outstanding;

	cpt_tick_if tick_ch ();
	cpt_disp_if #(.PRESET_W(3)) disp_ch ();

	cyclic_pump_timer_with_presets_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.disp      (disp_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cpt_display_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (tick_ch),
		.disp        (disp_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#150ms;
		$display("*** FAILED ***");
		$finish;
	end

	// display side back-pressure
	initial begin
		disp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				disp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			disp_ch.ready <= 1'b1;
		end
	end

	task automatic send_tick(input logic level);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			tick_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.button_level <= level;
		do @(posedge clk); while (!tick_ch.ready);
		ticks_sent++;
	endtask

	task automatic send_run(input logic level, input int unsigned n);
		repeat (n) send_tick(level);
	endtask

	// contact chatter ending on the opposite level
	task automatic send_chatter(input logic level);
		repeat ($urandom_range(0, 3)) begin
			send_tick(level);
			send_tick(!level);
		end
	endtask

	function automatic int unsigned press_length();
		if ($urandom_range(0, 4) == 0) begin
			return $urandom_range(1, debounce_now + 1);
		end
		return debounce_now + 1 + $urandom_range(0, 3);
	endfunction

	// wait until every display beat has come back
	task automatic settle();
		tick_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// unused upper data bits carry junk
	task automatic write_reg(input logic [1:0] idx, input logic [26:0] val,
			input int unsigned w);
		logic [26:0] junk;
		junk = $urandom();
		junk = junk << w;
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= junk | val;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [2:0] start, input logic [7:0] deb,
			input logic [26:0] green, input logic [15:0] ovl);
		write_reg(CFG_START_PRESET, start, 3);
		write_reg(CFG_DEBOUNCE, deb, 8);
		write_reg(CFG_GREEN_THRESH, green, 27);
		write_reg(CFG_OVERLAY, ovl, 16);
		cfg_wr_en <= 1'b0;
		debounce_now = deb;
	endtask

	task automatic random_regs();
		logic [7:0]  deb;
		logic [26:0] green;
		logic [15:0] ovl;
		case ($urandom_range(0, 3))
			0: deb = 8'd0;
			1: deb = 8'd1;
			2: deb = $urandom_range(2, 6);
			default: deb = $urandom_range(10, 30);
		endcase
		// zero, all ones, near an off interval so green shows up soon after a press, or random
		case ($urandom_range(0, 3))
			0: green = '0;
			1: green = '1;
			2: green = REST_MS[$urandom_range(0, 6)] - $urandom_range(0, 400);
			default: green = $urandom_range(0, 86400000);
		endcase
		case ($urandom_range(0, 3))
			0: ovl = 16'd0;
			1: ovl = $urandom_range(1, 20);
			2: ovl = $urandom_range(21, 200);
			default: ovl = 16'hffff;
		endcase
		program_regs($urandom_range(0, 7), deb, green, ovl);
	endtask

	task automatic button_session(input int unsigned items);
		int unsigned goal;
		goal = ticks_sent + items;
		while (ticks_sent < goal) begin
			if ($urandom_range(0, 9) < 2) begin
				repeat ($urandom_range(1, 8)) send_tick($urandom_range(0, 1));
			end else begin
				send_chatter(1'b1);
				send_run(1'b1, press_length());
				send_chatter(1'b0);
				send_run(1'b0, press_length());
			end
		end
	endtask

	initial begin : stimulus
		int unsigned idle_plan [6];
		logic [7:0]  pattern;
		int          i;
		idle_plan = '{20, 0, 40, 5, 20, 0};
		idle_pct = 0;
		ticks_sent = 0;
		debounce_now = DEBOUNCE_RST;
		arst_n = 1'b0;
		tick_ch.valid <= 1'b0;
		tick_ch.button_level <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_START_PRESET;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// settings after reset: pump on, red, a full minute left
		idle_pct = 10;
		send_run(1'b0, 3);
		settle();

		// instant debounce, no overlay, out-of-range start preset, always green:
		// seven presses walk every preset and wrap back to the first
		program_regs(3'd7, 8'd0, '1, 16'd0);
		repeat (7) begin
			send_tick(1'b1);
			send_tick(1'b0);
		end
		settle();

		// glitches shorter than the debounce, then a clean press with a short overlay
		program_regs(3'd0, 8'd2, '0, 16'd3);
		pattern = 8'b1011_1000;
		for (i = 7; i >= 0; i--) begin
			send_tick(pattern[i]);
		end
		settle();

		// longest debounce and overlay: a press held just past the debounce
		// moves to the shortest preset and opens a long overlay
		program_regs(3'd3, 8'd255, 27'd30000, 16'hffff);
		idle_pct = 1;
		send_run(1'b1, 260);
		send_run(1'b0, 40);
		settle();

		for (i = 0; i < 6; i++) begin
			random_regs();
			idle_pct = idle_plan[i];
			button_session(250);
			settle();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
